FILE: rtl/core/selection_sort_engine_macros.svh
// Assertion helpers for the sort engine.
`ifndef SELECTION_SORT_ENGINE_MACROS_SVH
`define SELECTION_SORT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSE_ASSERT(label, clk, rst, prop, msg)
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/sse_pkg.sv
`timescale 1ns / 1ps
package sse_pkg;

  localparam int DEF_MAX_ELEMENTS = 64;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic               item_last;
  } sse_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               sorted_last;
    logic               overflow;
  } sse_out_t;

  // control into the running-minimum unit
  typedef struct packed {
    logic vld;
    logic first;
  } sse_min_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SWAP1,
    S_SWAP2,
    S_EMIT,
    S_FLUSH
  } sse_state_t;

endpackage

FILE: rtl/core/sse_store.sv
`timescale 1ns / 1ps
module sse_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [31:0]   rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sse_min_unit.sv
`timescale 1ns / 1ps
module sse_min_unit
  import sse_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic               clk,
  input  sse_min_ctl_t       ctl,
  input  logic signed [31:0] data,
  input  logic [AW-1:0]      idx,
  output logic signed [31:0] best,
  output logic [AW-1:0]      best_idx
);

  // strict less keeps the higher index on ties, matching a downward scan
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || (data < best))) begin
      best     <= data;
      best_idx <= idx;
    end
  end

endmodule

FILE: rtl/core/selection_sort_engine.sv
`timescale 1ns / 1ps
// Channel   Ports                    Handshake
// input     item (sse_in_t)          start && !busy
// result    result (sse_out_t)       result_valid, one cycle, no stall
//
// Loading takes one cycle per item; busy stays low until the last item.
// Sorting is set by the single read port of the element store, which the
// minimum search walks one entry per cycle, followed per position by the
// drain and the two swap writes (S_DRAIN, S_SWAP1, S_SWAP2).
// Reset (rst, synchronous) clears the count, overflow flag and sequencer;
// the store itself is not cleared. Results cannot be stalled.
`include "selection_sort_engine_macros.svh"
module selection_sort_engine
  import sse_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sse_in_t  item,
  output sse_out_t result,
  output logic     result_valid
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  sse_state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic [AW-1:0] pos;
  logic [AW-1:0] k;
  logic [AW-1:0] top;
  logic          scan_vld;
  logic          scan_first;
  logic [AW-1:0] scan_idx;
  logic          emit_vld;
  logic          emit_last;
  logic signed [31:0] keep;

  logic               accept;
  logic               room;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;
  logic signed [31:0] best;
  logic [AW-1:0]      best_idx;
  sse_min_ctl_t       min_ctl;

  assign accept     = start && !busy;
  assign room       = count < CW'(MAX_ELEMENTS);
  assign count_next = room ? count + CW'(1) : count;

  sse_store #(
    .DEPTH(MAX_ELEMENTS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign min_ctl.vld   = scan_vld;
  assign min_ctl.first = scan_first;

  sse_min_unit #(
    .AW(AW)
  ) u_min (
    .clk     (clk),
    .ctl     (min_ctl),
    .data    (rdata),
    .idx     (scan_idx),
    .best    (best),
    .best_idx(best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = count[AW-1:0];
    wdata      = item.item_value;
    raddr      = k;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          we = room;
          if (item.item_last) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (k == pos) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_SWAP1;
      end
      S_SWAP1: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = best;
        state_next = S_SWAP2;
      end
      S_SWAP2: begin
        we         = 1'b1;
        waddr      = best_idx;
        wdata      = keep;
        state_next = (pos == top) ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        if (k == top) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      scan_vld <= 1'b0;
      emit_vld <= 1'b0;
    end else begin
      scan_vld <= (state == S_SCAN);
      emit_vld <= (state == S_EMIT);
      if (accept) begin
        count <= count_next;
        if (!room) begin
          ovf <= 1'b1;
        end
      end
      if (state == S_FLUSH) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // walk pointers and pipeline tags
  always_ff @(posedge clk) begin
    scan_first <= (k == top);
    scan_idx   <= k;
    emit_last  <= (k == top);
    case (state)
      S_IDLE: begin
        if (accept && item.item_last) begin
          top <= AW'(count_next - CW'(1));
          k   <= AW'(count_next - CW'(1));
          pos <= '0;
        end
      end
      S_SCAN: begin
        if (k != pos) begin
          k <= k - AW'(1);
        end
      end
      S_DRAIN: begin
        keep <= rdata;
      end
      S_SWAP2: begin
        if (pos == top) begin
          k <= '0;
        end else begin
          pos <= pos + AW'(1);
          k   <= top;
        end
      end
      S_EMIT: begin
        k <= k + AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign result_valid        = emit_vld;
  assign result.sorted_value = rdata;
  assign result.sorted_last  = emit_last;
  assign result.overflow     = ovf;

  `SSE_ASSERT(a_result_busy, clk, rst, !result_valid || busy, "result outside busy window")
  `SSE_ASSERT(a_scan_phase, clk, rst, !scan_vld || state == S_SCAN || state == S_DRAIN, "scan data outside scan")
  `SSE_ASSERT(a_count_cap, clk, rst, count <= CW'(MAX_ELEMENTS), "element count past capacity")
  `SSE_ASSERT_NEXT(a_swap_next, clk, rst, state == S_SWAP2, state == S_SCAN || state == S_EMIT, "bad step after swap")
  `SSE_ASSERT_NEXT(a_last_ends, clk, rst, result_valid && result.sorted_last, !result_valid && count == '0, "set not closed after last result")

endmodule
